FILE: src/adc_scan_sequencer_defines.svh
// assertion macros for the sequencer controller
// every macro samples on clk and stays quiet while arst_n is low
`ifndef ADC_SCAN_SEQUENCER_DEFINES_SVH
`define ADC_SCAN_SEQUENCER_DEFINES_SVH

// antecedent and consequent in the same cycle
`define ADCSEQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adc scan sequencer check failed");

// consequent in the following cycle
`define ADCSEQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adc scan sequencer check failed");

`endif

FILE: src/adcseq_pkg.sv
package adcseq_pkg;

	localparam int SEQ_DEPTH = 8;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 4;
	localparam int STEP_W    = 5;

	localparam logic [7:0] GAIN_MASK = 8'h07;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  entry_index;
		logic [7:0]  mux_channel_in;
		logic [7:0]  gain_factor;
		logic [7:0]  scan_count;
		logic [15:0] sample_value;
	} req_t;

	typedef struct packed {
		logic        start_conversion;
		logic [7:0]  mux_select;
		logic [2:0]  gain_code;
		logic        scan_done;
		logic [15:0] read_data;
		logic        rejected;
	} rsp_t;

	// decisions of the scan controller for the item in flight
	typedef struct packed {
		logic             tbl_we;
		logic             store_we;
		logic [IDX_W-1:0] store_idx;
		logic             cmd_en;
		logic [IDX_W-1:0] cmd_idx;
		logic             done;
		logic             rejected;
	} seq_ctl_t;

	// floor(log2(f)) for f above 1, else 0, kept to three bits
	function automatic logic [2:0] encode_gain(input logic [7:0] f);
		logic [7:0] code;
		code = 8'd0;
		for (int i = 1; i < 8; i++) begin
			if (f[i]) begin
				code = 8'(i);
			end
		end
		return 3'(code & GAIN_MASK);
	endfunction

endpackage

FILE: src/adcseq_table.sv
module adcseq_table (
	input  logic                          clk,
	input  logic                          we,
	input  logic [adcseq_pkg::IDX_W-1:0]  widx,
	input  logic [7:0]                    chan_in,
	input  logic [7:0]                    gain_in,
	input  logic [adcseq_pkg::IDX_W-1:0]  ridx,
	output logic [7:0]                    chan_out,
	output logic [2:0]                    code_out
);

	logic [7:0] chan_q [adcseq_pkg::SEQ_DEPTH];
	logic [2:0] code_q [adcseq_pkg::SEQ_DEPTH];

	// entries hold nothing meaningful until loaded
	always_ff @(posedge clk) begin
		if (we) begin
			chan_q[widx] <= chan_in;
			code_q[widx] <= adcseq_pkg::encode_gain(gain_in);
		end
	end

	assign chan_out = chan_q[ridx];
	assign code_out = code_q[ridx];

endmodule

FILE: src/adcseq_store.sv
module adcseq_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [adcseq_pkg::IDX_W-1:0]  widx,
	input  logic [15:0]                   wdata,
	input  logic [adcseq_pkg::IDX_W-1:0]  ridx,
	output logic [15:0]                   rdata
);

	logic [15:0] smp_q [adcseq_pkg::SEQ_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < adcseq_pkg::SEQ_DEPTH; i++) begin
				smp_q[i] <= 16'd0;
			end
		end else if (we) begin
			smp_q[widx] <= wdata;
		end
	end

	assign rdata = smp_q[ridx];

endmodule

FILE: src/adcseq_ctrl.sv
`include "adc_scan_sequencer_defines.svh"

module adcseq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  adcseq_pkg::req_t      req_s1,
	output adcseq_pkg::seq_ctl_t  ctl
);

	logic [adcseq_pkg::CNT_W-1:0]  active_q, active_d;
	logic [adcseq_pkg::STEP_W-1:0] step_q, step_d, step_inc;
	logic                          scanning_q, scanning_d;
	logic [adcseq_pkg::CNT_W-1:0]  slot_cur, slot_nxt, cnt_clamp;

	assign slot_cur = step_q[adcseq_pkg::STEP_W-1:1];
	assign step_inc = step_q + 5'd1;
	assign slot_nxt = step_inc[adcseq_pkg::STEP_W-1:1];
	assign cnt_clamp = (req_s1.scan_count < 8'(adcseq_pkg::SEQ_DEPTH))
		? 4'(req_s1.scan_count) : 4'(adcseq_pkg::SEQ_DEPTH);

	always_comb begin
		ctl        = '0;
		active_d   = active_q;
		step_d     = step_q;
		scanning_d = scanning_q;
		if (valid_s1) begin
			case (req_s1.req_type)
				adcseq_pkg::REQ_LOAD: begin
					if (scanning_q) begin
						ctl.rejected = 1'b1;
					end else begin
						ctl.tbl_we = 1'b1;
					end
				end
				adcseq_pkg::REQ_START: begin
					if (scanning_q) begin
						ctl.rejected = 1'b1;
					end else begin
						active_d   = cnt_clamp;
						step_d     = '0;
						scanning_d = 1'b1;
						ctl.cmd_en = 1'b1;
					end
				end
				adcseq_pkg::REQ_SAMPLE: begin
					if (scanning_q) begin
						ctl.store_we  = slot_cur < 4'(adcseq_pkg::SEQ_DEPTH);
						ctl.store_idx = slot_cur[adcseq_pkg::IDX_W-1:0];
						step_d        = step_inc;
						if (slot_nxt < active_q) begin
							ctl.cmd_en  = 1'b1;
							ctl.cmd_idx = slot_nxt[adcseq_pkg::IDX_W-1:0];
						end else begin
							scanning_d = 1'b0;
							ctl.done   = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			step_q     <= '0;
			scanning_q <= 1'b0;
		end else begin
			active_q   <= active_d;
			step_q     <= step_d;
			scanning_q <= scanning_d;
		end
	end

	`ADCSEQ_ASSERT_IMP(a_cmd_xor_done, ctl.cmd_en, !ctl.done)
	`ADCSEQ_ASSERT_IMP(a_slot_in_range, scanning_q, slot_cur <= active_q)
	`ADCSEQ_ASSERT_IMP(a_reject_only_scanning, ctl.rejected, scanning_q)
	`ADCSEQ_ASSERT_NXT(a_done_ends_scan, ctl.done, !scanning_q)
	`ADCSEQ_ASSERT_NXT(a_start_begins_scan,
		valid_s1 && req_s1.req_type == adcseq_pkg::REQ_START && !scanning_q,
		scanning_q && step_q == '0)

endmodule

FILE: src/adc_scan_sequencer.sv
// channel    handshake               payload
// request    start high, busy low    item   (adcseq_pkg::req_t)
// response   strobe, one cycle       result (adcseq_pkg::rsp_t)
//
// one transfer in every cycle while busy is low; each request gives exactly one
// result, through the input register and then the result register
// the scan state and the tables update on the same edge as the result, so
// back-to-back requests always see the effect of the one before
// busy is high only during reset and the first cycle after it
// the receiver cannot stall: strobe marks each result for one cycle only
module adc_scan_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  adcseq_pkg::req_t  item,
	output logic              strobe,
	output adcseq_pkg::rsp_t  result
);

	// reset release
	logic busy_q;

	// input register
	logic              valid_s1;
	adcseq_pkg::req_t  req_s1;

	// result register
	logic              strobe_q;
	adcseq_pkg::rsp_t  result_q;

	// controller decisions and table / store read data
	adcseq_pkg::seq_ctl_t ctl;
	logic [7:0]           tbl_chan;
	logic [2:0]           tbl_code;
	logic [15:0]          store_rdata;
	adcseq_pkg::rsp_t     rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	// capture each request transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			req_s1 <= item;
		end
	end

	// scan state: active count, step counter, scanning flag
	adcseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.ctl      (ctl)
	);

	// channel and gain table, loaded at entry_index, read at the commanded entry
	adcseq_table u_table (
		.clk      (clk),
		.we       (ctl.tbl_we),
		.widx     (req_s1.entry_index),
		.chan_in  (req_s1.mux_channel_in),
		.gain_in  (req_s1.gain_factor),
		.ridx     (ctl.cmd_idx),
		.chan_out (tbl_chan),
		.code_out (tbl_code)
	);

	// sample store, written at step/2, read at entry_index
	adcseq_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ctl.store_we),
		.widx   (ctl.store_idx),
		.wdata  (req_s1.sample_value),
		.ridx   (req_s1.entry_index),
		.rdata  (store_rdata)
	);

	// fields not belonging to this request stay at zero
	always_comb begin
		rsp_d                  = '0;
		rsp_d.start_conversion = ctl.cmd_en;
		rsp_d.mux_select       = ctl.cmd_en ? tbl_chan : 8'd0;
		rsp_d.gain_code        = ctl.cmd_en ? tbl_code : 3'd0;
		rsp_d.scan_done        = ctl.done;
		rsp_d.rejected         = ctl.rejected;
		if (req_s1.req_type == adcseq_pkg::REQ_READ) begin
			rsp_d.read_data = store_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= rsp_d;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule
